/* src/ghbdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ghbdc_pkg;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned PC_INDEX_BITS = 8;

	typedef struct packed {
		logic [63:0] access_address;
		logic [7:0]  pc_index;
		logic [4:0]  mshr_occupancy;
	} ghbdc_in_t;

	typedef struct packed {
		logic [63:0] prefetch_address;
		logic        fill_into_l2;
		logic        last_of_run;
	} ghbdc_out_t;

	localparam logic CFG_PREFETCH_DEGREE = 1'b0;
	localparam logic CFG_MSHR_THRESHOLD  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the input item
		logic lookup;     // read the PC table and the predecessor address
		logic append;     // write the new history entry
		logic walk_read;  // issue a read of the current chain entry
		logic walk_step;  // consume the entry that was read
		logic replay;     // build the next prefetch address
		logic out_load;   // move it into the output register
	} ghbdc_cmd_t;

	typedef struct packed {
		logic walk_done;   // chain ended, bound reached or pattern matched
		logic found;       // a match with at least one delta to replay
		logic replay_more; // more deltas and degree remain
	} ghbdc_sts_t;

endpackage
`default_nettype wire

/* src/ghbdc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module ghbdc_datapath
	import ghbdc_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ghbdc_in_t  in_item,
	input  wire ghbdc_cmd_t cmd,
	input  wire logic [2:0] degree,
	input  wire logic [4:0] threshold,
	output ghbdc_sts_t      sts,
	output ghbdc_out_t      result
);
	localparam int unsigned HB = $clog2(HISTORY_DEPTH);
	localparam int unsigned PCN = 1 << PC_INDEX_BITS;

	logic [63:0] hist_addr_mem [HISTORY_DEPTH];
	logic [63:0] hist_delta_mem [HISTORY_DEPTH];
	logic [HB-1:0] hist_link_mem [HISTORY_DEPTH];
	logic [HB-1:0] pc_last_mem [PCN];
	logic [PCN-1:0] pc_valid_q;

	logic [63:0] addr_q;
	logic [PC_INDEX_BITS-1:0] pc_q;
	logic fill_q;
	logic [HB-1:0] head_q;
	logic [HB-1:0] cur_q;
	logic [HB-1:0] pred_q;
	logic pred_valid_q;
	logic [63:0] pred_addr_q;

	logic [HB-1:0] rd_link_q;
	logic [63:0] rd_delta_q;

	logic [HB:0] dist_q;
	logic [HB:0] n_q;
	logic [1:0] phase_q;
	logic [63:0] first_q, second_q;
	// The newest walked deltas shift through here. At a match the deltas to
	// replay sit two places behind the matching entry, oldest first.
	logic [63:0] trail_q [MAX_RESULTS + 2];
	logic done_q, found_q;
	logic [HB:0] kcount_q;
	logic [2:0] produced_q;
	logic [63:0] pa_q;

	logic [HB-1:0] pc_ptr;
	logic [HB:0] step_dist;
	logic [HB+1:0] dist_sum;
	logic [2:0] lim;

	assign lim = (degree > 3'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : degree;
	assign step_dist = (cur_q > rd_link_q) ? {1'b0, cur_q - rd_link_q}
		: (HB+1)'(HISTORY_DEPTH) - {1'b0, rd_link_q - cur_q};
	assign dist_sum = {1'b0, dist_q} + {1'b0, step_dist};

	always_ff @(posedge clk) begin
		pc_ptr <= pc_last_mem[pc_q];
		if (cmd.append) begin
			pc_last_mem[pc_q] <= head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			pred_addr_q <= hist_addr_mem[pc_ptr];
		end
		if (cmd.walk_read) begin
			rd_link_q <= hist_link_mem[cur_q];
			rd_delta_q <= hist_delta_mem[cur_q];
		end
		if (cmd.append) begin
			hist_addr_mem[head_q] <= addr_q;
			hist_link_mem[head_q] <= pred_valid_q ? pred_q : head_q;
			hist_delta_mem[head_q] <= pred_valid_q ? addr_q - pred_addr_q : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_valid_q <= '0;
			head_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			phase_q <= 2'd0;
			n_q <= '0;
			dist_q <= '0;
			produced_q <= '0;
			kcount_q <= '0;
		end else begin
			if (cmd.capture) begin
				done_q <= 1'b0;
				found_q <= 1'b0;
				phase_q <= 2'd0;
				n_q <= '0;
				dist_q <= '0;
				produced_q <= '0;
			end
			if (cmd.lookup) begin
				pred_valid_q <= pc_valid_q[pc_q];
				pred_q <= pc_ptr;
			end
			if (cmd.append) begin
				pc_valid_q[pc_q] <= 1'b1;
				cur_q <= head_q;
				head_q <= (head_q == HB'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (cmd.walk_step) begin
				if (rd_link_q == cur_q || dist_sum >= (HB+2)'(HISTORY_DEPTH)) begin
					done_q <= 1'b1;
				end else begin
					dist_q <= dist_sum[HB:0];
					n_q <= n_q + 1'b1;
					trail_q[0] <= rd_delta_q;
					for (int i = 1; i < MAX_RESULTS + 2; i++) begin
						trail_q[i] <= trail_q[i-1];
					end
					cur_q <= rd_link_q;
					unique case (phase_q)
						2'd0: begin
							second_q <= rd_delta_q;
							phase_q <= 2'd1;
						end
						2'd1: begin
							first_q <= rd_delta_q;
							phase_q <= 2'd2;
						end
						2'd2: begin
							if (rd_delta_q == second_q) phase_q <= 2'd3;
						end
						default: begin
							if (rd_delta_q == first_q) begin
								done_q <= 1'b1;
								// A match needs both deltas of the pair, so at
								// least two deltas always precede it.
								found_q <= 1'b1;
								kcount_q <= n_q - 2'd1;
							end else if (rd_delta_q != second_q) begin
								phase_q <= 2'd2;
							end
						end
					endcase
				end
			end
			if (cmd.replay) begin
				pa_q <= (produced_q == 3'd0 ? addr_q : pa_q)
					+ trail_q[produced_q + 3'd2];
				kcount_q <= kcount_q - 1'b1;
				produced_q <= produced_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= in_item.access_address;
			pc_q <= in_item.pc_index[PC_INDEX_BITS-1:0];
			fill_q <= in_item.mshr_occupancy < threshold;
		end
		if (cmd.out_load) begin
			result.prefetch_address <= pa_q;
			result.fill_into_l2 <= fill_q;
			result.last_of_run <= !(kcount_q != '0 && produced_q < lim);
		end
	end

	assign sts.walk_done = done_q;
	assign sts.found = found_q && lim != 3'd0;
	assign sts.replay_more = kcount_q != '0 && produced_q < lim;
endmodule
`default_nettype wire

/* src/ghbdc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ghbdc_ctrl
	import ghbdc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire ghbdc_sts_t sts,
	output ghbdc_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_APND = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_PLAY = 3'd5;
	localparam logic [2:0] ST_LOAD = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q, state_d;
	logic ptr_wait_q;

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// The PC table read is registered after pc_q is captured, so lookup waits for ptr_wait_q.
				if (ptr_wait_q) begin
					cmd.lookup = 1'b1;
					state_d = ST_APND;
				end
			end
			ST_APND: begin
				cmd.append = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.walk_read = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (sts.walk_done) begin
					state_d = sts.found ? ST_PLAY : ST_IDLE;
				end else begin
					cmd.walk_step = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_PLAY: begin
				cmd.replay = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d = ST_OUT;
			end
			default: begin
				if (!out_stall) begin
					state_d = sts.replay_more ? ST_PLAY : ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_wait_q <= state_q == ST_LOOK && !ptr_wait_q;
		end
	end
endmodule
`default_nettype wire

/* src/ghb_delta_correlation_prefetcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// GHB PC/DC prefetcher. Each access is appended to the global history buffer,
// then its PC chain is walked one link at a time (a memory read, then a compare
// per link) until a repeat of the newest delta pair, a chain end, or
// HISTORY_DEPTH of wrap distance. The input is stalled until the access is done.
// Prefetch addresses come out in order, the last marked by last_of_run.
module ghb_delta_correlation_prefetcher
	import ghbdc_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire ghbdc_in_t  in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output ghbdc_out_t      out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);
	ghbdc_cmd_t cmd;
	ghbdc_sts_t sts;
	logic [2:0] degree_q;
	logic [4:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 3'd4;
			threshold_q <= 5'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PREFETCH_DEGREE: degree_q <= cfg_data[2:0];
				default: threshold_q <= cfg_data[4:0];
			endcase
		end
	end

	ghbdc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	ghbdc_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .degree(degree_q),
		.threshold(threshold_q), .sts, .result(out_data)
	);
endmodule
`default_nettype wire

/* src/ghbdc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ghbdc_checker
	import ghbdc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire ghbdc_out_t out_data
);
	// Results come only while an item is being worked on.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result while idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// After the last result of a run the block is free again.
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last_of_run |=> !in_stall)
		else $error("block busy after last transfer");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second item taken");
endmodule
bind ghb_delta_correlation_prefetcher ghbdc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
